[rtl/csc_pkg.sv]
package csc_pkg;

  // Results one column may produce, and the width of a counter that holds it.
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Beat widths on the two channels.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  // Walker to result pipeline: a read was issued for a closing row.
  typedef struct packed {
    logic       issue;
    logic [7:0] row;
    logic [8:0] end_col;
    logic       fin;
  } csc_walk_t;

  // Result pipeline back to the walker.
  typedef struct packed {
    logic s1_free;
    logic drained;
  } csc_outst_t;

endpackage

[rtl/column_to_span_converter_core.sv]
// Column-to-span converter for one floor or ceiling area.
// The input channel takes one beat per screen column, left to right, holding
// the column index and the row extents of the previous and current column.
// For every screen row that the previous column covered and the current one
// does not, up to MAX_RESULTS per column, the output channel gives one beat:
// the row, its stored start column and the current column minus one. Rows
// closed at the top come first in ascending order, then rows closed at the
// bottom in descending order; out_tlast marks the last beat of a column.
// Columns that close nothing give no beat. Rows that open store the column
// as their start in a RAM. An accepted input beat is first reduced modulo
// the screen width, then walked row by row in four walks (closing top,
// closing bottom, opening top, opening bottom), after which the walker waits
// for the result pipeline to drain. Rows past the last screen row, and
// closing rows past MAX_RESULTS, are skipped without being walked. Each
// closing row that gives a beat costs one read of the RAM's read port; the
// result pipeline moves one beat per cycle while the receiver is ready.
// A new column is taken only after all beats of the previous one have reached
// the output register. A stalled receiver holds the output beat and, once the
// result pipeline is full, pauses the walk. Reset empties the pipeline and
// returns to idle; stored start columns are not cleared.
module column_to_span_converter_core
  import csc_pkg::*;
#(
  parameter int ROWS    = 64,
  parameter int COLUMNS = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // column[9:0], prev_top[17:10], prev_bottom[25:18], cur_top[33:26],
  // cur_bottom[41:34], zero fill[47:42]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // span_row[5:0], span_begin[14:6], span_end[23:15]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // final_span
  output logic                  out_tlast
);

  localparam int AW = $clog2(ROWS);

  csc_walk_t  walk;
  csc_outst_t ost;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [8:0]    wdata, rdata;

  // Sequencer for the four row walks.
  csc_walker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .ost       (ost),
    .walk      (walk),
    .re        (re),
    .raddr     (raddr),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata)
  );

  // Start column of every row.
  csc_ram #(
    .WIDTH (9),
    .DEPTH (ROWS)
  ) u_start_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read stage, last-beat hold stage and output register.
  csc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .walk       (walk),
    .rdata      (rdata),
    .ost        (ost),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[rtl/csc_ram.sv]
module csc_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/csc_walker.sv]
module csc_walker
  import csc_pkg::*;
#(
  parameter int ROWS    = 64,
  parameter int COLUMNS = 512
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_W-1:0]    in_tdata,
  input  csc_outst_t              ost,
  output csc_walk_t               walk,
  output logic                    re,
  output logic [$clog2(ROWS)-1:0] raddr,
  output logic                    we,
  output logic [$clog2(ROWS)-1:0] waddr,
  output logic [8:0]              wdata
);

  localparam int AW       = $clog2(ROWS);
  // Reciprocal of the screen width, exact for every 10-bit column index.
  localparam int RCP_SH   = 10 + $clog2(COLUMNS);
  localparam int RCP_M    = ((1 << RCP_SH) + COLUMNS - 1) / COLUMNS;
  localparam int END_WRAP = (COLUMNS - 1) % 512;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CTOP   = 3'd2;
  localparam logic [2:0] ST_CBOT   = 3'd3;
  localparam logic [2:0] ST_OTOP   = 3'd4;
  localparam logic [2:0] ST_OBOT   = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  localparam logic [7:0] ROWS_M1 = 8'(ROWS - 1);
  localparam logic [8:0] ROWS_9  = 9'(ROWS);

  logic [2:0]       state_r, state_nxt;
  logic [9:0]       col_r, col_nxt;
  logic [7:0]       t1_r, t1_nxt, b1_r, b1_nxt;
  logic [7:0]       t2_r, t2_nxt, b2_r, b2_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic        cap;
  logic        t1_in, b1_in, t2_in, b2_in;
  logic [8:0]  b1p1, b2p1;
  logic [7:0]  t1_end, t2_end, b1_lo, b2_lo;
  logic [7:0]  wrow;
  logic [9:0]  col_m1;
  logic        issue;
  logic [21:0] col_prod;
  logic [9:0]  col_quo;
  logic [22:0] col_back;
  logic [9:0]  col_rem;

  assign cap   = (cnt_r == CNT_W'(MAX_RESULTS));
  assign t1_in = ({1'b0, t1_r} < ROWS_9);
  assign b1_in = ({1'b0, b1_r} < ROWS_9);
  assign t2_in = ({1'b0, t2_r} < ROWS_9);
  assign b2_in = ({1'b0, b2_r} < ROWS_9);

  // Where a walk that produces nothing more lands in one step.
  assign b1p1   = {1'b0, b1_r} + 9'd1;
  assign b2p1   = {1'b0, b2_r} + 9'd1;
  assign t1_end = ({1'b0, t2_r} < b1p1) ? t2_r : b1p1[7:0];
  assign t2_end = ({1'b0, t1_r} < b2p1) ? t1_r : b2p1[7:0];
  assign b1_lo  = (t1_r == 8'd0) ? b2_r :
                  (((t1_r - 8'd1) > b2_r) ? (t1_r - 8'd1) : b2_r);
  assign b2_lo  = (t2_r == 8'd0) ? b1_r :
                  (((t2_r - 8'd1) > b1_r) ? (t2_r - 8'd1) : b1_r);

  // Column modulo the screen width: quotient by reciprocal multiplication,
  // then the remainder from one multiply-back and subtract.
  assign col_prod = 22'(col_r) * 22'(RCP_M);
  assign col_quo  = 10'(col_prod >> RCP_SH);
  assign col_back = 23'(col_quo) * 23'(COLUMNS);
  assign col_rem  = col_r - col_back[9:0];

  assign col_m1 = col_r - 10'd1;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    t1_nxt    = t1_r;
    b1_nxt    = b1_r;
    t2_nxt    = t2_r;
    b2_nxt    = b2_r;
    cnt_nxt   = cnt_r;
    issue     = 1'b0;
    we        = 1'b0;
    wrow      = t2_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          col_nxt   = in_tdata[9:0];
          t1_nxt    = in_tdata[17:10];
          b1_nxt    = in_tdata[25:18];
          t2_nxt    = in_tdata[33:26];
          b2_nxt    = in_tdata[41:34];
          cnt_nxt   = '0;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        col_nxt   = col_rem;
        state_nxt = ST_CTOP;
      end
      ST_CTOP: begin
        if (t1_r < t2_r && t1_r <= b1_r) begin
          if (!t1_in || cap) begin
            t1_nxt = t1_end;
          end else if (ost.s1_free) begin
            issue   = 1'b1;
            t1_nxt  = t1_r + 8'd1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          state_nxt = ST_CBOT;
        end
      end
      ST_CBOT: begin
        if (b1_r > b2_r && b1_r >= t1_r) begin
          if (cap) begin
            b1_nxt = b1_lo;
          end else if (!b1_in) begin
            b1_nxt = (b1_lo > ROWS_M1) ? b1_lo : ROWS_M1;
          end else if (ost.s1_free) begin
            issue   = 1'b1;
            b1_nxt  = b1_r - 8'd1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else begin
          state_nxt = ST_OTOP;
        end
      end
      ST_OTOP: begin
        if (t2_r < t1_r && t2_r <= b2_r) begin
          if (t2_in) begin
            we     = 1'b1;
            wrow   = t2_r;
            t2_nxt = t2_r + 8'd1;
          end else begin
            t2_nxt = t2_end;
          end
        end else begin
          state_nxt = ST_OBOT;
        end
      end
      ST_OBOT: begin
        if (b2_r > b1_r && b2_r >= t2_r) begin
          if (b2_in) begin
            we     = 1'b1;
            wrow   = b2_r;
            b2_nxt = b2_r - 8'd1;
          end else begin
            b2_nxt = (b2_lo > ROWS_M1) ? b2_lo : ROWS_M1;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ost.drained) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    col_r <= col_nxt;
    t1_r  <= t1_nxt;
    b1_r  <= b1_nxt;
    t2_r  <= t2_nxt;
    b2_r  <= b2_nxt;
    cnt_r <= cnt_nxt;
  end

  assign in_tready = (state_r == ST_IDLE);

  assign walk.issue   = issue;
  assign walk.row     = (state_r == ST_CTOP) ? t1_r : b1_r;
  assign walk.end_col = (col_r == 10'd0) ? 9'(END_WRAP) : col_m1[8:0];
  assign walk.fin     = (state_r == ST_FIN);

  assign re    = issue;
  assign raddr = walk.row[AW-1:0];
  assign waddr = wrow[AW-1:0];
  assign wdata = col_r[8:0];

endmodule

[rtl/csc_out.sv]
module csc_out
  import csc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  csc_walk_t             walk,
  input  logic [8:0]            rdata,
  output csc_outst_t            ost,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  // Read stage: the row whose start column is coming out of the RAM.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_row_r;
  logic [8:0] s1_end_r;

  // Hold stage: one span kept back until it is known whether it is the last.
  logic       h_valid_r, h_valid_nxt;
  logic [5:0] h_row_r;
  logic [8:0] h_begin_r;
  logic [8:0] h_end_r;

  logic                  o_valid_r, o_valid_nxt;
  logic [OUT_DATA_W-1:0] o_data_r;
  logic                  o_last_r;

  logic o_free, flush, h_out, s1_move;

  assign o_free  = !o_valid_r || out_tready;
  assign flush   = walk.fin && !s1_valid_r;
  assign h_out   = h_valid_r && o_free && (s1_valid_r || flush);
  assign s1_move = s1_valid_r && (!h_valid_r || h_out);

  assign s1_valid_nxt = walk.issue ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign h_valid_nxt  = s1_move ? 1'b1 : (h_out ? 1'b0 : h_valid_r);
  assign o_valid_nxt  = h_out ? 1'b1 : (out_tready ? 1'b0 : o_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      h_valid_r  <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      h_valid_r  <= h_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
    if (walk.issue) begin
      s1_row_r <= walk.row;
      s1_end_r <= walk.end_col;
    end
    if (s1_move) begin
      h_row_r   <= s1_row_r[5:0];
      h_begin_r <= rdata;
      h_end_r   <= s1_end_r;
    end
    if (h_out) begin
      o_data_r <= {h_end_r, h_begin_r, h_row_r};
      o_last_r <= flush;
    end
  end

  assign ost.s1_free = !s1_valid_r || s1_move;
  assign ost.drained = !s1_valid_r && !h_valid_r;

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tlast  = o_last_r;

endmodule

[rtl/csc_checker.sv]
module csc_checker
  import csc_pkg::*;
#(
  parameter int ROWS    = 64,
  parameter int COLUMNS = 512
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second column taken before the first was walked");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ROWS > 63) || (32'(out_tdata[5:0]) < ROWS))
    else $error("span row beyond the last screen row");

  a_end_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (COLUMNS > 511) || (32'(out_tdata[23:15]) < COLUMNS))
    else $error("span end beyond the last screen column");

endmodule

bind column_to_span_converter_core csc_checker #(
  .ROWS    (ROWS),
  .COLUMNS (COLUMNS)
) u_csc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/testbench.sv]
module testbench;
  import csc_pkg::*;

  // Screen rows the block keeps start columns for; taller rows are clipped.
  localparam int SCREEN_ROWS = 64;

  // The random part runs this many columns after the directed plan.
  localparam int RANDOM_COLUMNS = 240;

  // Cycles without any accepted beat, on either channel, before the run is
  // declared hung. The slowest correct column walks four extents of up to
  // 256 rows each, and the sender's gaps, the receiver's stalls and the final
  // settling wait are all far shorter than this limit, so it is several
  // times what a correct block ever needs.
  localparam int HANG_LIMIT = 5000;

  // Cycles to wait after the last expected span so that a block still
  // busy with the last column can finish its work.
  localparam int SETTLE_CYCLES = 600;

  // One input beat: a screen column with the extents of the previous and
  // the current column. A top below its bottom row marks an empty column.
  typedef struct packed {
    logic [9:0] column;
    logic [7:0] prev_top;
    logic [7:0] prev_bottom;
    logic [7:0] cur_top;
    logic [7:0] cur_bottom;
  } column_beat_t;

  // One output beat: a closed horizontal span.
  typedef struct packed {
    logic [5:0] row;
    logic [8:0] first_col;
    logic [8:0] last_col;
    logic       tail;
  } span_t;

  // How a row of the directed plan is checked: no span at all, one span
  // typed into the plan, or whatever the span predictor works out.
  typedef enum logic [1:0] {
    SPANS_NONE,
    SPANS_ONE,
    SPANS_PREDICTED
  } plan_check_t;

  typedef struct packed {
    column_beat_t beat;
    plan_check_t  check;
    span_t        span;
  } plan_row_t;

  // Receiver behavior, changed now and then at random.
  typedef enum logic [1:0] {
    DRAIN_OPEN,
    DRAIN_CHOPPY,
    DRAIN_THROTTLED,
    DRAIN_STALLS
  } drain_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // column[9:0], prev_top[17:10], prev_bottom[25:18], cur_top[33:26],
  // cur_bottom[41:34], zero fill[47:42]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // span_row[5:0], span_begin[14:6], span_end[23:15]
  logic [OUT_DATA_W-1:0] out_tdata;
  // final_span
  logic                  out_tlast;

  column_to_span_converter_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the start column stored for every screen row, and the
  // spans that the block still owes us, oldest first.
  logic [8:0] row_start [0:SCREEN_ROWS-1];
  span_t      expected_spans[$];
  plan_row_t  plan[$];

  int mismatch_count = 0;
  int columns_taken  = 0;
  int spans_checked  = 0;
  int widest_column  = 0;
  int idle_cycles    = 0;

  // Sender pacing: beats go out in bursts; in a steady stretch the sender
  // never idles at all.
  int burst_left     = 0;
  bit steady_stretch = 1'b0;

  // Works out the spans one accepted column closes and updates the stored
  // start columns. Rows that close are read before any row of the same column
  // opens, top closes first (ascending), then bottom closes (descending).
  // With record cleared only the stored starts are updated; the directed plan
  // uses that for rows whose spans are typed in by hand.
  function automatic void predict_column(input column_beat_t c, input bit record);
    int         top_prev;
    int         bot_prev;
    int         top_cur;
    int         bot_cur;
    int         closed[$];
    logic [8:0] open_col;
    logic [8:0] close_col;
    span_t      s;
    top_prev  = c.prev_top;
    bot_prev  = c.prev_bottom;
    top_cur   = c.cur_top;
    bot_cur   = c.cur_bottom;
    // Columns wrap at the 512-wide screen; a span ends one column back, so
    // column 0 closes at the last screen column.
    open_col  = c.column[8:0];
    close_col = c.column[8:0] - 9'd1;
    while (top_prev < top_cur && top_prev <= bot_prev) begin
      if (top_prev < SCREEN_ROWS && closed.size() < MAX_RESULTS) closed.push_back(top_prev);
      top_prev++;
    end
    while (bot_prev > bot_cur && bot_prev >= top_prev) begin
      if (bot_prev < SCREEN_ROWS && closed.size() < MAX_RESULTS) closed.push_back(bot_prev);
      bot_prev--;
    end
    if (closed.size() > widest_column) widest_column = closed.size();
    if (record) begin
      foreach (closed[i]) begin
        s.row       = closed[i][5:0];
        s.first_col = row_start[closed[i]];
        s.last_col  = close_col;
        s.tail      = (i == closed.size() - 1);
        expected_spans.push_back(s);
      end
    end
    // Rows that the current column newly covers remember it as their start.
    while (top_cur < top_prev && top_cur <= bot_cur) begin
      if (top_cur < SCREEN_ROWS) row_start[top_cur] = open_col;
      top_cur++;
    end
    while (bot_cur > bot_prev && bot_cur >= top_cur) begin
      if (bot_cur < SCREEN_ROWS) row_start[bot_cur] = open_col;
      bot_cur--;
    end
  endfunction

  function automatic int clamp_row(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  task automatic add_plan(input int column, input int pt, input int pb, input int ct,
                          input int cb, input plan_check_t check, input int row = 0,
                          input int first_col = 0, input int last_col = 0);
    plan_row_t r;
    r.beat.column      = column[9:0];
    r.beat.prev_top    = pt[7:0];
    r.beat.prev_bottom = pb[7:0];
    r.beat.cur_top     = ct[7:0];
    r.beat.cur_bottom  = cb[7:0];
    r.check            = check;
    r.span.row         = row[5:0];
    r.span.first_col   = first_col[8:0];
    r.span.last_col    = last_col[8:0];
    r.span.tail        = 1'b1;
    plan.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input span_t want, input span_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] %s: expected row %0d begin %0d end %0d last %0b,",
               $time, what, want.row, want.first_col, want.last_col, want.tail);
      $display("    got row %0d begin %0d end %0d last %0b",
               got.row, got.first_col, got.last_col, got.tail);
    end
  endtask

  // Presents one column and returns at the edge where it was accepted.
  // The caller predicts the column in that same time step, before any spans
  // of it can leave the block.
  task automatic offer_column(input column_beat_t c);
    in_tdata  <= {6'd0, c.cur_bottom, c.cur_top, c.prev_bottom, c.prev_top, c.column};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    columns_taken++;
  endtask

  // Between beats: inside a burst the next column follows at once, otherwise
  // the sender idles for a random gap and starts a new burst.
  task automatic sender_pause();
    int gap;
    if (!steady_stretch) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        gap = $urandom_range(1, 8);
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 12);
      end
    end
  endtask

  // Holds the sender off until every span already owed has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_spans.size() != 0);
  endtask

  // Receiver: a stall pattern of its own, switching between always ready,
  // coin-flip ready, one cycle in four, and mostly ready with long stalls.
  drain_mode_t drain_mode = DRAIN_OPEN;
  int          drain_left = 0;
  int          stall_left = 0;
  bit          ready_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (drain_left == 0) begin
        drain_mode = drain_mode_t'($urandom_range(0, 3));
        drain_left = $urandom_range(16, 200);
      end else begin
        drain_left--;
      end
      case (drain_mode)
        DRAIN_OPEN: begin
          ready_next = 1'b1;
        end
        DRAIN_CHOPPY: begin
          ready_next = $urandom_range(0, 1);
        end
        DRAIN_THROTTLED: begin
          ready_next = (drain_left % 4 == 0);
        end
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 24);
          end
        end
      endcase
      out_tready <= ready_next;
    end
  end

  // Span checker: every accepted output beat is held against the oldest
  // expected span, field by field. A beat with nothing owed is a failure.
  span_t got_span;
  span_t want_span;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_span.row       = out_tdata[5:0];
      got_span.first_col = out_tdata[14:6];
      got_span.last_col  = out_tdata[23:15];
      got_span.tail      = out_tlast;
      if (expected_spans.size() == 0) begin
        note_mismatch("span beat with nothing pending", got_span, got_span);
      end else begin
        want_span = expected_spans.pop_front();
        spans_checked++;
        if (got_span.row !== want_span.row || got_span.first_col !== want_span.first_col ||
            got_span.last_col !== want_span.last_col || got_span.tail !== want_span.tail) begin
          note_mismatch("span mismatch", want_span, got_span);
        end
      end
    end
  end

  // Hang detection: any accepted beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("[%0t] no beat accepted for %0d cycles, %0d spans still pending",
                 $time, HANG_LIMIT, expected_spans.size());
        $display("column_to_span_converter_core regression: fail");
        $finish;
      end
    end
  end

  column_beat_t beat;
  int           trace_top;
  int           trace_bottom;
  int           trace_col;
  int           seq_len;
  int           random_done;
  int           pick;
  bit           fresh;
  bit           paused_once;

  initial begin
    // Directed plan. The first column opens every screen row, so no span
    // ever reads a start column that was never written.
    add_plan(0,    1,   0,   0,   63,  SPANS_NONE);
    add_plan(1,    0,   63,  0,   63,  SPANS_NONE);
    // One row closed at the top, then one at the bottom.
    add_plan(2,    0,   63,  1,   63,  SPANS_ONE, 0, 0, 1);
    add_plan(3,    1,   63,  1,   62,  SPANS_ONE, 63, 0, 2);
    add_plan(4,    1,   62,  0,   63,  SPANS_NONE);
    // Every row closes at once: the most spans one column can give, and the
    // opening walk runs into clipped rows.
    add_plan(5,    0,   63,  255, 255, SPANS_PREDICTED);
    add_plan(6,    255, 255, 0,   63,  SPANS_NONE);
    // Closes at both ends, then a disjoint jump down the screen.
    add_plan(7,    0,   63,  10,  20,  SPANS_PREDICTED);
    add_plan(8,    10,  20,  30,  40,  SPANS_PREDICTED);
    add_plan(9,    30,  40,  0,   255, SPANS_NONE);
    // Column 0 wraps its span end to the last screen column; the bottom
    // walk crosses clipped rows.
    add_plan(0,    0,   255, 5,   250, SPANS_PREDICTED);
    // One past the last column: clipped rows give nothing, row 63 closes.
    add_plan(512,  5,   250, 5,   62,  SPANS_ONE, 63, 9, 511);
    add_plan(1023, 5,   62,  0,   62,  SPANS_NONE);
    add_plan(513,  0,   62,  1,   62,  SPANS_ONE, 0, 511, 0);
    // Both columns empty, then an empty previous column whose bounds lie
    // inside the new extent.
    add_plan(20,   200, 100, 255, 0,   SPANS_NONE);
    add_plan(21,   50,  40,  0,   63,  SPANS_NONE);
    // An empty current column with crossed bounds closes from both ends.
    add_plan(22,   0,   63,  40,  30,  SPANS_PREDICTED);
    // Single-row columns moving up and down.
    add_plan(23,   255, 0,   0,   0,   SPANS_NONE);
    add_plan(24,   0,   0,   1,   1,   SPANS_ONE, 0, 23, 23);
    add_plan(25,   1,   1,   0,   0,   SPANS_ONE, 1, 24, 24);
    add_plan(26,   0,   0,   255, 255, SPANS_ONE, 0, 25, 25);
    add_plan(1023, 255, 255, 255, 255, SPANS_NONE);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      offer_column(plan[i].beat);
      predict_column(plan[i].beat, plan[i].check == SPANS_PREDICTED);
      if (plan[i].check == SPANS_ONE) expected_spans.push_back(plan[i].span);
      sender_pause();
    end

    // Random part. Most columns come in runs where each column's previous
    // extent is the one sent just before, as a real floor area is walked;
    // the rest are unrelated noise columns.
    random_done  = 0;
    paused_once  = 1'b0;
    trace_top    = 255;
    trace_bottom = 0;
    trace_col    = 0;
    while (random_done < RANDOM_COLUMNS) begin
      steady_stretch = ($urandom_range(0, 3) == 0);
      if (!paused_once && random_done >= RANDOM_COLUMNS / 2) begin
        wait_drained();
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 99) < 15) begin
        beat = column_beat_t'({$urandom, $urandom});
        offer_column(beat);
        predict_column(beat, 1'b1);
        sender_pause();
        random_done++;
      end else begin
        seq_len = $urandom_range(3, 24);
        fresh   = $urandom_range(0, 1);
        if (fresh) begin
          // A new area starts from an empty column somewhere on the screen.
          trace_top    = $urandom_range(1, 255);
          trace_bottom = $urandom_range(0, trace_top - 1);
          trace_col    = $urandom_range(0, 1023);
        end
        for (int k = 0; k < seq_len && random_done < RANDOM_COLUMNS; k++) begin
          beat.column      = trace_col[9:0];
          beat.prev_top    = trace_top[7:0];
          beat.prev_bottom = trace_bottom[7:0];
          pick = (fresh && k == 0) ? 80 : $urandom_range(0, 99);
          if (pick < 60) begin
            // Neighboring columns usually differ by a few rows.
            trace_top    = clamp_row(trace_top + int'($urandom_range(0, 6)) - 3);
            trace_bottom = clamp_row(trace_bottom + int'($urandom_range(0, 6)) - 3);
          end else if (pick < 75) begin
            trace_top    = $urandom_range(1, 255);
            trace_bottom = $urandom_range(0, trace_top - 1);
          end else if (pick < 92) begin
            // Mostly on screen, sometimes reaching past the last row.
            trace_top    = $urandom_range(0, 70);
            trace_bottom = $urandom_range(0, 90);
          end else begin
            trace_top    = $urandom_range(0, 255);
            trace_bottom = $urandom_range(0, 255);
          end
          beat.cur_top    = trace_top[7:0];
          beat.cur_bottom = trace_bottom[7:0];
          trace_col       = (trace_col + 1) % 1024;
          offer_column(beat);
          predict_column(beat, 1'b1);
          sender_pause();
          random_done++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d columns (%0d from the directed plan), %0d spans checked",
             columns_taken, plan.size(), spans_checked);
    $display("widest column closed %0d spans; %0d mismatches", widest_column, mismatch_count);
    if (mismatch_count == 0 && expected_spans.size() == 0) begin
      $display("column_to_span_converter_core regression: pass");
    end else begin
      $display("column_to_span_converter_core regression: fail");
    end
    $finish;
  end

endmodule
